// ===== design/nnwo_pkg.sv =====
// Shared types and constants for the nearest-neighbor waypoint ordering block.
package nnwo_pkg;

  localparam int COORD_BITS     = 24;
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAG_W          = COORD_BITS + 1;
  localparam int SQ_W           = 2 * MAG_W;
  localparam int SUM_W          = SQ_W + 2;

  typedef enum logic [1:0] {
    OP_SET_START = 2'd0,
    OP_LOAD      = 2'd1,
    OP_ORDER     = 2'd2
  } nnwo_op_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } nnwo_point_t;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } nnwo_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         last;
    logic                         overflowed;
  } nnwo_out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } nnwo_tag_t;

endpackage

// ===== design/nnwo_ram.sv =====
// Generic simple dual-port RAM with registered read.
module nnwo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nnwo_dist.sv =====
// Three-stage squared-distance pipeline: magnitudes, squares, sum.
module nnwo_dist import nnwo_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nnwo_point_t        pt_i,
  input  nnwo_point_t        cur_i,
  input  nnwo_tag_t          tag_i,
  input  logic [IDX_W-1:0]   idx_i,
  output nnwo_point_t        pt_o,
  output nnwo_tag_t          tag_o,
  output logic [IDX_W-1:0]   idx_o,
  output logic [SUM_W-1:0]   sum_o
);

  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] cc [3];
  logic signed [MAG_W-1:0]      diff [3];
  logic [MAG_W-1:0]             mag_d [3];
  logic [MAG_W-1:0]             mag_q [3];
  logic [SQ_W-1:0]              sq_d [3];
  logic [SQ_W-1:0]              sq_q [3];
  logic [SUM_W-1:0]             sum_d;
  logic [SUM_W-1:0]             sum_q;

  nnwo_point_t      pt_a_q, pt_b_q, pt_c_q;
  nnwo_tag_t        tag_a_q, tag_b_q, tag_c_q;
  logic [IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q;

  always_comb begin
    pc[0] = pt_i.x;
    pc[1] = pt_i.y;
    pc[2] = pt_i.z;
    cc[0] = cur_i.x;
    cc[1] = cur_i.y;
    cc[2] = cur_i.z;
    for (int k = 0; k < 3; k++) begin
      diff[k]  = $signed({pc[k][COORD_BITS-1], pc[k]}) - $signed({cc[k][COORD_BITS-1], cc[k]});
      mag_d[k] = diff[k][MAG_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
      sq_d[k]  = SQ_W'(mag_q[k]) * SQ_W'(mag_q[k]);
    end
    sum_d = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    sq_q    <= sq_d;
    sum_q   <= sum_d;
    pt_a_q  <= pt_i;
    pt_b_q  <= pt_a_q;
    pt_c_q  <= pt_b_q;
    idx_a_q <= idx_i;
    idx_b_q <= idx_a_q;
    idx_c_q <= idx_b_q;
  end

  assign pt_o  = pt_c_q;
  assign tag_o = tag_c_q;
  assign idx_o = idx_c_q;
  assign sum_o = sum_q;

endmodule

// ===== design/nearest_neighbor_waypoint_order_top.sv =====
// Greedy nearest-neighbor waypoint ordering: store, scan sequencer and best-point tracking.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): each request sets the start
// position, loads a waypoint, or orders the stored waypoints. Set and load stay in
// the idle state, ready for the next request. A load into a full store is dropped
// and sets a sticky overflow flag that only reset clears. Operation code 3 is ignored.
// An order request on N stored points runs N scans of the point RAM from the current
// position. Each scan reads one entry per cycle through the single RAM read port,
// then waits in the drain state for the RAM read and the distance pipeline, and then
// the emit state loads the best point, stalling while the output is full. Each chosen
// point is loaded into the output register (out_valid_o/out_ready_i/out_data_o);
// the final one has last set.
// The next scan starts while a result waits; a stalled receiver holds the sequencer
// only when the next result is ready. An empty store emits nothing.
// New requests are taken once the last result is in the output register, even if it
// is not yet taken. The store empties after every tour; the position stays at the
// last emitted point. Reset clears the count, the position, the flag and the output.
module nearest_neighbor_waypoint_order_top import nnwo_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nnwo_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nnwo_out_t out_data_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [IDX_W-1:0]    scan_idx_q, scan_idx_d;
  logic [MAX_POINTS-1:0] visited_q, visited_d;
  nnwo_point_t         cur_q, cur_d;
  logic                ovf_q, ovf_d;
  logic                have_q, have_d;
  logic [SUM_W-1:0]    best_sum_q, best_sum_d;
  nnwo_point_t         best_pt_q, best_pt_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  nnwo_tag_t           tag_q, tag_d;
  logic [IDX_W-1:0]    idx_q;
  nnwo_out_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                in_fire, out_free, store_we, scan_end, tour_last, better;
  logic [CNT_W-1:0]    count_m1;
  nnwo_point_t         in_pt, ram_pt, p_pt;
  nnwo_tag_t           p_tag;
  logic [IDX_W-1:0]    p_idx;
  logic [SUM_W-1:0]    p_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign count_m1   = count_q - CNT_W'(1);
  assign scan_end   = (CNT_W'(scan_idx_q) == count_m1);
  assign tour_last  = ((step_q + CNT_W'(1)) == count_q);
  assign in_pt      = '{z: in_data_i.pos_z, y: in_data_i.pos_y, x: in_data_i.pos_x};
  assign store_we   = in_fire && (in_data_i.operation == OP_LOAD) &&
                      (count_q < CNT_W'(MAX_POINTS));

  nnwo_ram #(
    .WIDTH ($bits(nnwo_point_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_pt),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_pt)
  );

  nnwo_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (ram_pt),
    .cur_i  (cur_q),
    .tag_i  (tag_q),
    .idx_i  (idx_q),
    .pt_o   (p_pt),
    .tag_o  (p_tag),
    .idx_o  (p_idx),
    .sum_o  (p_sum)
  );

  // Equal distance: smaller Y wins, then the lower index already held.
  assign better = !have_q || (p_sum < best_sum_q) ||
                  ((p_sum == best_sum_q) && (p_pt.y < best_pt_q.y));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    scan_idx_d  = scan_idx_q;
    visited_d   = visited_q;
    cur_d       = cur_q;
    ovf_d       = ovf_q;
    have_d      = have_q;
    best_sum_d  = best_sum_q;
    best_pt_d   = best_pt_q;
    best_idx_d  = best_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tag_d       = '0;

    if (state_q == ST_SCAN) begin
      tag_d.valid = !visited_q[scan_idx_q];
      tag_d.last  = scan_end;
    end

    if (p_tag.valid && better) begin
      have_d     = 1'b1;
      best_sum_d = p_sum;
      best_pt_d  = p_pt;
      best_idx_d = p_idx;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.operation)
            OP_SET_START: cur_d = in_pt;
            OP_LOAD: begin
              if (store_we) begin
                count_d = count_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_ORDER: begin
              if (count_q != '0) begin
                state_d    = ST_SCAN;
                step_d     = '0;
                scan_idx_d = '0;
                have_d     = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_idx_d = scan_idx_q + IDX_W'(1);
        if (scan_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p_tag.last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.out_x           = best_pt_q.x;
          out_d.out_y           = best_pt_q.y;
          out_d.out_z           = best_pt_q.z;
          out_d.last            = tour_last;
          out_d.overflowed      = ovf_q;
          cur_d                 = best_pt_q;
          visited_d[best_idx_q] = 1'b1;
          have_d                = 1'b0;
          if (tour_last) begin
            state_d   = ST_IDLE;
            count_d   = '0;
            visited_d = '0;
          end else begin
            state_d    = ST_SCAN;
            step_d     = step_q + CNT_W'(1);
            scan_idx_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      scan_idx_q  <= '0;
      visited_q   <= '0;
      cur_q       <= '0;
      ovf_q       <= 1'b0;
      have_q      <= 1'b0;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      scan_idx_q  <= scan_idx_d;
      visited_q   <= visited_d;
      cur_q       <= cur_d;
      ovf_q       <= ovf_d;
      have_q      <= have_d;
      tag_q       <= tag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_sum_q <= best_sum_d;
    best_pt_q  <= best_pt_d;
    best_idx_q <= best_idx_d;
    idx_q      <= scan_idx_q;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/nnwo_checker.sv =====
// Port-level checks for the waypoint ordering block, bound to the top level.
module nnwo_checker import nnwo_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input nnwo_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input nnwo_out_t out_data_o
);

  logic seen_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ovf_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && out_data_o.overflowed) begin
      seen_ovf_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_busy_mid_tour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("request taken while a tour is in progress");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_ovf_q |-> out_data_o.overflowed)
    else $error("overflow flag cleared without reset");

endmodule

bind nearest_neighbor_waypoint_order_top nnwo_checker u_nnwo_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the greedy nearest-neighbor waypoint ordering block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nnwo_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CMAX        = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN        = -(1 << (COORD_BITS - 1));
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam int MAX_LOGGED  = 40;

  typedef struct {
    int x;
    int y;
    int z;
  } coord_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  nnwo_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  nnwo_out_t out_data;

  logic      in_taken  = 1'b0;
  logic      hold_go   = 1'b0;
  logic      hold_on   = 1'b0;
  int        idle_pct  = 0;
  int        stall_pct = 0;
  int        err_cnt   = 0;
  int        n_counted = 0;

  // Shadow of the block state
  coord_t    wp_store [MAX_POINTS_DEF];
  int        wp_count  = 0;
  coord_t    cur_pos   = '{0, 0, 0};
  bit        ovf_flag  = 1'b0;

  nnwo_in_t  pend_q [$];
  nnwo_out_t tour_q [$];
  nnwo_out_t exp_r;

  nearest_neighbor_waypoint_order_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_err(string msg);
    err_cnt++;
    if (err_cnt <= MAX_LOGGED) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  function automatic longint sq_dist(coord_t a, coord_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic void predict_request(nnwo_in_t req);
    coord_t                  p;
    bit [MAX_POINTS_DEF-1:0] seen;
    int                      best;
    longint                  d, best_d;
    nnwo_out_t               r;
    p.x = $signed(req.pos_x);
    p.y = $signed(req.pos_y);
    p.z = $signed(req.pos_z);
    case (req.operation)
      OP_SET_START: cur_pos = p;
      OP_LOAD: begin
        if (wp_count < MAX_POINTS_DEF) begin
          wp_store[wp_count] = p;
          wp_count++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OP_ORDER: begin
        seen = '0;
        for (int s = 0; s < wp_count; s++) begin
          best   = -1;
          best_d = 0;
          for (int i = 0; i < wp_count; i++) begin
            if (!seen[i]) begin
              d = sq_dist(cur_pos, wp_store[i]);
              if (best < 0 || d < best_d ||
                  (d == best_d && wp_store[i].y < wp_store[best].y)) begin
                best   = i;
                best_d = d;
              end
            end
          end
          seen[best]   = 1'b1;
          cur_pos      = wp_store[best];
          r.out_x      = cur_pos.x[COORD_BITS-1:0];
          r.out_y      = cur_pos.y[COORD_BITS-1:0];
          r.out_z      = cur_pos.z[COORD_BITS-1:0];
          r.last       = (s == wp_count - 1);
          r.overflowed = ovf_flag;
          tour_q.push_back(r);
        end
        wp_count = 0;
      end
      default: ;
    endcase
  endfunction

  // Driver: new request at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    wait (hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // Monitor
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (tour_q.size() == 0) begin
          report_err("result with nothing expected");
        end else begin
          exp_r = tour_q.pop_front();
          if (out_data.out_x !== exp_r.out_x)
            report_err($sformatf("out_x got %h exp %h", out_data.out_x, exp_r.out_x));
          if (out_data.out_y !== exp_r.out_y)
            report_err($sformatf("out_y got %h exp %h", out_data.out_y, exp_r.out_y));
          if (out_data.out_z !== exp_r.out_z)
            report_err($sformatf("out_z got %h exp %h", out_data.out_z, exp_r.out_z));
          if (out_data.last !== exp_r.last)
            report_err($sformatf("last got %b exp %b", out_data.last, exp_r.last));
          if (out_data.overflowed !== exp_r.overflowed)
            report_err($sformatf("overflowed got %b exp %b",
                                 out_data.overflowed, exp_r.overflowed));
        end
      end
      if (in_valid && in_ready) predict_request(in_data);
    end
  end

  function automatic void push_req(logic [1:0] op, int x, int y, int z);
    nnwo_in_t r;
    r.operation = op;
    r.pos_x     = x[COORD_BITS-1:0];
    r.pos_y     = y[COORD_BITS-1:0];
    r.pos_z     = z[COORD_BITS-1:0];
    pend_q.push_back(r);
    if (op != OP_UNUSED) n_counted++;
  endfunction

  // 0 full range, 1 tiny range for ties, 2 extremes, 3 moderate range
  function automatic int rand_coord(int mode);
    logic [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    case (mode)
      1: return int'($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0: return CMIN;
          1: return CMAX;
          2: return 0;
          default: return -1;
        endcase
      end
      3: return int'($urandom_range(2000)) - 1000;
      default: return int'($signed(v));
    endcase
  endfunction

  function automatic void push_batch(int k, int mode);
    repeat (k) push_req(OP_LOAD, rand_coord(mode), rand_coord(mode), rand_coord(mode));
    push_req(OP_ORDER, rand_coord(0), rand_coord(0), rand_coord(0));
  endfunction

  function automatic void push_random(int n_items);
    int target, k, mode;
    logic [1:0] op;
    target = n_counted + n_items;
    while (n_counted < target) begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(2))
          0: op = OP_SET_START;
          1: op = OP_ORDER;
          default: op = OP_UNUSED;
        endcase
        push_req(op, rand_coord(0), rand_coord(0), rand_coord(0));
      end else begin
        mode = $urandom_range(3);
        if ($urandom_range(1))
          push_req(OP_SET_START, rand_coord(mode), rand_coord(mode), rand_coord(mode));
        k = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
        push_batch(k, mode);
      end
    end
  endfunction

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || tour_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    push_req(OP_ORDER, 0, 0, 0);
    push_req(OP_UNUSED, CMAX, CMIN, -1);
    push_req(OP_SET_START, CMIN, CMIN, CMIN);
    push_req(OP_LOAD, CMAX, CMAX, CMAX);
    push_req(OP_LOAD, CMIN, CMIN, CMIN);
    push_req(OP_ORDER, -1, -1, -1);
    // next tour starts where the last one ended
    push_req(OP_LOAD, 0, 0, 0);
    push_req(OP_LOAD, CMAX, CMAX, CMAX - 1);
    push_req(OP_LOAD, CMIN, CMAX, CMIN);
    push_req(OP_ORDER, CMAX, CMIN, CMAX);
    // equal distances: smaller Y first, then load order
    push_req(OP_SET_START, 0, 0, 0);
    push_req(OP_LOAD, 3, 0, 0);
    push_req(OP_LOAD, 0, 0, 3);
    push_req(OP_LOAD, 0, -3, 0);
    push_req(OP_ORDER, 0, 0, 0);
    push_req(OP_LOAD, 5, -5, 5);
    push_req(OP_ORDER, 0, 0, 0);
    push_req(OP_LOAD, 7, 7, 7);
    push_req(OP_LOAD, 7, 7, 7);
    push_req(OP_ORDER, CMIN, CMAX, 0);
    push_req(OP_ORDER, 0, 0, 0);
    drain();

    // long receiver hold-off while requests keep coming
    hold_go = 1'b1;
    push_batch(20, 0);
    push_batch(5, 1);
    push_batch(3, 2);
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    push_random(35);
    push_batch(MAX_POINTS_DEF, 3);
    push_random(35);
    drain();

    idle_pct  = 88;
    stall_pct = 0;
    push_random(80);
    drain();

    idle_pct  = 0;
    stall_pct = 88;
    push_random(80);
    drain();

    idle_pct  = 19;
    stall_pct = 19;
    push_random(35);
    push_batch(MAX_POINTS_DEF + 2, 1);
    push_random(35);
    drain();

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
